// ----- hdl/kt_pkg.sv -----
// Package: shared widths, constants and the cell link type for the max-profit chain.
`timescale 1ns / 1ps

package kt_pkg;

  localparam int PRICE_W           = 16;
  localparam int PROFIT_W          = 32;
  localparam int CFG_W             = 5;
  localparam int HOLD_W            = 34;
  localparam int FLAT_W            = 33;
  localparam int MAX_TRANS_DEFAULT = 16;

  localparam logic [CFG_W-1:0]         CFG_RESET    = CFG_W'(2);
  localparam logic signed [HOLD_W-1:0] HOLD_NEG_INF = {1'b1, {(HOLD_W-1){1'b0}}};

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [PRICE_W-1:0] price;
    logic [FLAT_W-1:0]  flat;
  } kt_link_t;

endpackage

// ----- hdl/k_transaction_max_profit.sv -----
// Top level: best profit over at most k buy-sell pairs, systolic chain of transaction cells.
`timescale 1ns / 1ps

// Prices enter one per cycle and move down a chain of MAX_TRANS_LIMIT cells, one cell per
// transaction count; cell t updates its holding and flat values from the link registered by
// cell t-1. A sequence ends with the price whose last flag is set. Its profit is taken from
// the cell that matches max_transactions (clamped to MAX_TRANS_LIMIT) and is captured in
// the output register; a limit of zero gives zero. Throughput is one price per cycle, and
// sequences may follow each other without gaps. The whole chain
// holds still only while a finished result waits in the output register and another result
// reaches the tap cell. Write max_transactions only while the block is idle.

module k_transaction_max_profit #(
  parameter int MAX_TRANS_LIMIT = kt_pkg::MAX_TRANS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kt_pkg::PRICE_W-1:0]    price,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kt_pkg::PROFIT_W-1:0]   profit,
  input  logic                          cfg_we,
  input  logic [kt_pkg::CFG_W-1:0]      cfg_data
);

  localparam int LIM_W = $clog2(MAX_TRANS_LIMIT + 1);

  logic [kt_pkg::CFG_W-1:0] max_transactions;
  logic [LIM_W-1:0]         lim;
  logic [LIM_W-1:0]         tap;
  logic                     pending;
  logic                     adv;
  logic [kt_pkg::PROFIT_W-1:0] result;

  kt_pkg::kt_link_t links [0:MAX_TRANS_LIMIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_transactions <= kt_pkg::CFG_RESET;
    end else if (cfg_we) begin
      max_transactions <= cfg_data;
    end
  end

  always_comb begin
    if (32'(max_transactions) > MAX_TRANS_LIMIT) begin
      lim = LIM_W'(MAX_TRANS_LIMIT);
    end else begin
      lim = LIM_W'(max_transactions);
    end
    tap     = (lim == '0) ? LIM_W'(1) : lim;
    pending = links[tap].valid & links[tap].last;
    adv     = !(pending && out_valid && !out_ready);
    if (lim == '0) begin
      result = '0;
    end else if (links[tap].flat[kt_pkg::FLAT_W-1:kt_pkg::PROFIT_W] != '0) begin
      result = '1;
    end else begin
      result = links[tap].flat[kt_pkg::PROFIT_W-1:0];
    end
  end

  assign in_ready = adv;

  always_comb begin
    links[0].valid = in_valid;
    links[0].last  = last;
    links[0].price = price;
    links[0].flat  = '0;
  end

  for (genvar i = 1; i <= MAX_TRANS_LIMIT; i++) begin : g_cell
    kt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .link_in  (links[i-1]),
      .link_out (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pending && adv) begin
        out_valid <= 1'b1;
        profit    <= result;
      end
    end
  end

endmodule

// ----- hdl/kt_cell.sv -----
// Cell: holding and flat state for one transaction count, registered hand-off to the next cell.
`timescale 1ns / 1ps

module kt_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  kt_pkg::kt_link_t link_in,
  output kt_pkg::kt_link_t link_out
);

  logic signed [kt_pkg::HOLD_W-1:0] hold;
  logic [kt_pkg::FLAT_W-1:0]        flat;

  logic signed [kt_pkg::HOLD_W-1:0] flat_in_s;
  logic signed [kt_pkg::HOLD_W-1:0] flat_s;
  logic signed [kt_pkg::HOLD_W-1:0] price_s;
  logic signed [kt_pkg::HOLD_W-1:0] h_cand;
  logic signed [kt_pkg::HOLD_W-1:0] h_new;
  logic signed [kt_pkg::HOLD_W-1:0] f_cand;
  logic [kt_pkg::FLAT_W-1:0]        f_new;

  always_comb begin
    flat_in_s = signed'({1'b0, link_in.flat});
    flat_s    = signed'({1'b0, flat});
    price_s   = signed'(kt_pkg::HOLD_W'(link_in.price));
    h_cand    = flat_in_s - price_s;
    h_new     = (h_cand > hold) ? h_cand : hold;
    f_cand    = h_new + price_s;
    f_new     = (f_cand > flat_s) ? f_cand[kt_pkg::FLAT_W-1:0] : flat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
      hold           <= kt_pkg::HOLD_NEG_INF;
      flat           <= '0;
    end else if (en) begin
      link_out.valid <= link_in.valid;
      link_out.last  <= link_in.last;
      link_out.price <= link_in.price;
      link_out.flat  <= f_new;
      if (link_in.valid) begin
        // end of sequence: pass the result on, start fresh
        if (link_in.last) begin
          hold <= kt_pkg::HOLD_NEG_INF;
          flat <= '0;
        end else begin
          hold <= h_new;
          flat <= f_new;
        end
      end
    end
  end

endmodule

// ----- test/tb_k_transaction_max_profit.sv -----
// Testbench for k_transaction_max_profit: random price sequences checked against a predictor.
`timescale 1ns / 1ps

module tb_k_transaction_max_profit;
  import kt_pkg::*;

  localparam int CELLS          = MAX_TRANS_DEFAULT;
  localparam int SETTLE_CYCLES  = 2 * CELLS + 8;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRICES_PER_SET = 120;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

  class kt_profit_board;
    logic signed [HOLD_W-1:0] holding [1:CELLS];
    logic [FLAT_W-1:0]        flat [0:CELLS];
    logic [CFG_W-1:0]         limit;
    logic [PROFIT_W-1:0]      expected_profits [$];
    int                       mismatches;
    int                       checked;

    function new();
      limit      = CFG_RESET;
      mismatches = 0;
      checked    = 0;
      clear();
    endfunction

    function void clear();
      flat[0] = '0;
      for (int t = 1; t <= CELLS; t++) begin
        holding[t] = HOLD_NEG_INF;
        flat[t]    = '0;
      end
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      limit = v;
    endfunction

    function void take_price(logic [PRICE_W-1:0] p, logic is_last);
      logic signed [HOLD_W:0] pe;
      logic signed [HOLD_W:0] held;
      logic signed [HOLD_W:0] hold_try;
      logic signed [HOLD_W:0] flat_try;
      logic [FLAT_W-1:0]      best;
      int                     lim;
      pe = $signed({{(HOLD_W + 1 - PRICE_W){1'b0}}, p});
      for (int t = 1; t <= CELLS; t++) begin
        hold_try = $signed({2'b00, flat[t-1]}) - pe;
        held     = $signed({holding[t][HOLD_W-1], holding[t]});
        if (hold_try > held) holding[t] = hold_try[HOLD_W-1:0];
        held     = $signed({holding[t][HOLD_W-1], holding[t]});
        flat_try = held + pe;
        if (flat_try > $signed({2'b00, flat[t]})) flat[t] = flat_try[FLAT_W-1:0];
      end
      if (is_last) begin
        lim  = (limit > CELLS) ? CELLS : int'(limit);
        best = (lim == 0) ? '0 : flat[lim];
        // clamp to the output range
        if (best[FLAT_W-1:PROFIT_W] != '0) expected_profits.push_back('1);
        else expected_profits.push_back(best[PROFIT_W-1:0]);
        clear();
      end
    endfunction

    function void check_profit(logic [PROFIT_W-1:0] got);
      logic [PROFIT_W-1:0] want;
      if (expected_profits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected profit %0d", $realtime, got);
      end else begin
        want = expected_profits.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: profit mismatch, expected %0d, got %0d", $realtime, want, got);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [PRICE_W-1:0]  price;
  logic                last;
  logic                out_valid;
  logic                out_ready;
  logic [PROFIT_W-1:0] profit;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_data;

  kt_profit_board board;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  holdoff_req;
  int  quiet_cycles;
  int  prices_taken;
  int  sequences_taken;

  k_transaction_max_profit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .price     (price),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .profit    (profit),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // transfers and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_profit(profit);
      if (in_valid && in_ready) begin
        board.take_price(price, last);
        prices_taken++;
        if (last) sequences_taken++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_price(input logic [PRICE_W-1:0] p, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    price    <= p;
    last     <= l;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.expected_profits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_limit(v);
  endtask

  task automatic send_sequence(output int len);
    int style;
    int walk;
    logic [PRICE_W-1:0] p;
    len   = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 48);
    style = $urandom_range(3);
    walk  = $urandom_range(65535);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: p = PRICE_W'($urandom_range(65535));
        1: begin
          walk = walk + $urandom_range(2000) - 1000;
          if (walk < 0) walk = 0;
          if (walk > 65535) walk = 65535;
          p = PRICE_W'(walk);
        end
        2: p = ($urandom_range(1)) ? PRICE_MAX : '0;
        default: p = PRICE_W'($urandom_range(15));
      endcase
      send_price(p, i == len - 1);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] limit_set [9];
    int sent;
    int len;
    limit_set = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd17, 5'd3, 5'd2, 5'd12};
    board           = new();
    rst             = 1'b1;
    in_valid        = 1'b0;
    price           = '0;
    last            = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    holdoff_req     = 1'b0;
    quiet_cycles    = 0;
    prices_taken    = 0;
    sequences_taken = 0;
    send_idle_pct   = 33;
    recv_idle_pct   = 76;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limit of two: lone price, one trade, two trades
    send_price(PRICE_MAX, 1'b1);
    send_price('0, 1'b0);
    send_price(PRICE_MAX, 1'b1);
    send_price(PRICE_MAX, 1'b0);
    send_price('0, 1'b0);
    send_price(PRICE_MAX, 1'b0);
    send_price('0, 1'b0);
    send_price(PRICE_MAX, 1'b1);
    // limit changed in the middle of a sequence
    send_price('0, 1'b0);
    send_price(PRICE_MAX, 1'b0);
    send_price('0, 1'b0);
    settle();
    write_limit(5'd1);
    send_price(PRICE_MAX, 1'b1);
    // zero limit
    settle();
    write_limit(5'd0);
    send_price('0, 1'b0);
    send_price(PRICE_MAX, 1'b1);
    // limit above the chain length
    settle();
    write_limit(5'd31);
    for (int i = 0; i < 6; i++) send_price((i % 2) ? PRICE_MAX : '0, i == 5);

    for (int s = 0; s < 9; s++) begin
      settle();
      write_limit(limit_set[s]);
      if (s < 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 76;
      end else if (s < 6) begin
        send_idle_pct = 76;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long result-side stall with the sender streaming
      if (s == 8) holdoff_req = 1'b1;
      sent = 0;
      while (sent < PRICES_PER_SET) begin
        send_sequence(len);
        sent += len;
      end
    end
    settle();

    $display("Run covered %0d prices in %0d sequences, %0d profits checked, %0d mismatches.",
             prices_taken, sequences_taken, board.checked, board.mismatches);
    $display("Limits 0 to 31 incl. a mid-sequence change, idle mixes and a long output stall.");
    if (board.mismatches == 0 && board.expected_profits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/kt_pkg.sv
hdl/kt_cell.sv
hdl/k_transaction_max_profit.sv
test/tb_k_transaction_max_profit.sv
